// File: sv/swwe_pkg.sv
package swwe_pkg;

  localparam int PosW     = 32;
  localparam int LenW     = 31;
  localparam int StW      = 8;
  localparam int NumW     = 9;
  localparam int EnW      = 33;
  localparam int CfgIdxW  = 3;
  localparam int CfgW     = 32;
  localparam int DivSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOWER = 3'd0,
    REG_UPPER = 3'd1,
    REG_DIAM  = 3'd2,
    REG_RANGE = 3'd3,
    REG_DEPTH = 3'd4,
    REG_NUM   = 3'd5,
    REG_BOX   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [PosW-1:0] lower;
    logic signed [PosW-1:0] upper;
    logic [LenW-1:0]        diam;
    logic [LenW-1:0]        well_rng;
    logic [LenW-1:0]        depth;
    logic [LenW-1:0]        box;
    logic [NumW-1:0]        m_eff;
  } cfg_t;

  // word carried through the divide pipeline
  typedef struct packed {
    logic                   err;
    logic                   neg;
    logic                   s_zero;
    logic signed [PosW-1:0] z;
    logic [PosW-1:0]        mag;
    logic [PosW-1:0]        zrem;
    logic [LenW-1:0]        dw;
    logic [NumW-1:0]        drem;
    logic [LenW-1:0]        ew;
    logic [NumW-1:0]        erem;
  } div_word_t;

  typedef struct packed {
    logic                   err;
    logic signed [PosW-1:0] zw;
    logic [LenW-1:0]        d_use;
    logic [LenW-1:0]        e_use;
  } fix_word_t;

  typedef struct packed {
    logic            err;
    logic            ovl;
    logic            wu;
    logic            wl;
    logic [LenW-1:0] e_use;
  } cmp_word_t;

endpackage

// File: sv/swwe_ifs.sv
interface swwe_in_if import swwe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] z_position;
  logic [StW-1:0]         ensemble_state;

  modport source(output valid, z_position, ensemble_state, input ready);
  modport sink(input valid, z_position, ensemble_state, output ready);
endinterface

interface swwe_out_if import swwe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [EnW-1:0] energy;
  logic                  infinite;
  logic                  is_inside;
  logic                  status;

  modport source(output valid, energy, infinite, is_inside, status, input ready);
  modport sink(input valid, energy, infinite, is_inside, status, output ready);
endinterface

// File: sv/swwe_front.sv
module swwe_front import swwe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  swwe_in_if.sink   in_if,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_word_t dn_word
);

  logic            v_r;
  div_word_t       w_r;
  div_word_t       w_nxt;
  logic [PosW-1:0] zu;
  logic [38:0]     pd;
  logic [38:0]     pe;

  assign in_if.ready = !v_r || dn_ready;
  assign dn_valid    = v_r;
  assign dn_word     = w_r;

  always_comb begin
    zu = in_if.z_position;
    pd = 39'(cfg.diam) * 39'(in_if.ensemble_state);
    pe = 39'(cfg.depth) * 39'(in_if.ensemble_state);
    w_nxt.err    = {1'b0, in_if.ensemble_state} >= cfg.m_eff;
    w_nxt.neg    = zu[PosW-1];
    w_nxt.s_zero = in_if.ensemble_state == '0;
    w_nxt.z      = in_if.z_position;
    w_nxt.mag    = zu[PosW-1] ? (~zu + 32'd1) : zu;
    w_nxt.zrem   = '0;
    w_nxt.dw     = pd[30:0];
    w_nxt.drem   = {1'b0, pd[38:31]};
    w_nxt.ew     = pe[30:0];
    w_nxt.erem   = {1'b0, pe[38:31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_if.ready) begin
      v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      w_r <= w_nxt;
    end
  end

endmodule

// File: sv/swwe_div.sv
module swwe_div import swwe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_word_t dn_word
);

  // one restoring step: wrap remainder always, state scaling when scale set
  function automatic div_word_t div_step(div_word_t w, cfg_t c, logic scale);
    div_word_t       o;
    logic [PosW-1:0] t;
    logic [NumW:0]   td;
    logic [NumW:0]   te;
    o  = w;
    t  = {w.zrem[30:0], w.mag[PosW-1]};
    td = {w.drem, w.dw[LenW-1]};
    te = {w.erem, w.ew[LenW-1]};
    if (t >= {1'b0, c.box}) begin
      o.zrem = t - {1'b0, c.box};
    end else begin
      o.zrem = t;
    end
    o.mag = {w.mag[PosW-2:0], 1'b0};
    if (scale) begin
      if (td >= {1'b0, c.m_eff}) begin
        o.drem = NumW'(td - {1'b0, c.m_eff});
        o.dw   = {w.dw[LenW-2:0], 1'b1};
      end else begin
        o.drem = td[NumW-1:0];
        o.dw   = {w.dw[LenW-2:0], 1'b0};
      end
      if (te >= {1'b0, c.m_eff}) begin
        o.erem = NumW'(te - {1'b0, c.m_eff});
        o.ew   = {w.ew[LenW-2:0], 1'b1};
      end else begin
        o.erem = te[NumW-1:0];
        o.ew   = {w.ew[LenW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [DivSteps-1:0] v_r;
  div_word_t           w_r [DivSteps];
  logic [DivSteps:0]   rdy;

  assign rdy[DivSteps] = dn_ready;
  assign up_ready      = rdy[0];
  assign dn_valid      = v_r[DivSteps-1];
  assign dn_word       = w_r[DivSteps-1];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic      v_in;
    div_word_t w_in;

    if (k == 0) begin : g_first
      assign v_in = up_valid;
      assign w_in = up_word;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign w_in = w_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in) begin
        w_r[k] <= div_step(w_in, cfg, k != 0);
      end
    end
  end

endmodule

// File: sv/swwe_back.sv
module swwe_back import swwe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_word,
  swwe_out_if.source out_if
);

  logic      fv_r;
  fix_word_t f_r;
  fix_word_t f_nxt;
  logic      cv_r;
  cmp_word_t c_r;
  cmp_word_t c_nxt;
  logic      ov_r;
  logic signed [EnW-1:0] energy_r;
  logic signed [EnW-1:0] energy_nxt;
  logic      inf_r;
  logic      ins_r;
  logic      st_r;
  logic      f_rdy;
  logic      c_rdy;
  logic      o_rdy;

  logic signed [35:0] z2;
  logic signed [35:0] up2;
  logic signed [35:0] lo2;
  logic signed [33:0] zx;
  logic signed [33:0] upr;
  logic signed [33:0] lor;
  logic [EnW-1:0]     e1;
  logic [EnW-1:0]     esum;

  assign o_rdy    = !ov_r || out_if.ready;
  assign c_rdy    = !cv_r || o_rdy;
  assign f_rdy    = !fv_r || c_rdy;
  assign up_ready = f_rdy;

  // periodic wrap fixup and scale select
  always_comb begin
    f_nxt.err = up_word.err;
    if (cfg.box == '0) begin
      f_nxt.zw = up_word.z;
    end else if (up_word.neg && (up_word.zrem != '0)) begin
      f_nxt.zw = $signed({1'b0, cfg.box} - up_word.zrem);
    end else begin
      f_nxt.zw = $signed(up_word.zrem);
    end
    f_nxt.d_use = up_word.s_zero ? cfg.diam  : up_word.dw;
    f_nxt.e_use = up_word.s_zero ? cfg.depth : up_word.ew;
  end

  // wall compares: overlap on doubled positions, well range on plain positions
  always_comb begin
    z2  = $signed({{3{f_r.zw[PosW-1]}}, f_r.zw, 1'b0});
    up2 = $signed({{3{cfg.upper[PosW-1]}}, cfg.upper, 1'b0} - {5'd0, f_r.d_use});
    lo2 = $signed({{3{cfg.lower[PosW-1]}}, cfg.lower, 1'b0} + {5'd0, f_r.d_use});
    zx  = $signed({{2{f_r.zw[PosW-1]}}, f_r.zw});
    upr = $signed({{2{cfg.upper[PosW-1]}}, cfg.upper} - {3'd0, cfg.well_rng});
    lor = $signed({{2{cfg.lower[PosW-1]}}, cfg.lower} + {3'd0, cfg.well_rng});
    c_nxt.err   = f_r.err;
    c_nxt.ovl   = (z2 >= up2) || (z2 <= lo2);
    c_nxt.wu    = zx > upr;
    c_nxt.wl    = zx < lor;
    c_nxt.e_use = f_r.e_use;
  end

  always_comb begin
    e1         = {2'b00, c_r.e_use};
    esum       = (c_r.wu ? e1 : '0) + (c_r.wl ? e1 : '0);
    energy_nxt = $signed(33'd0 - esum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
      cv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (f_rdy) begin
        fv_r <= up_valid;
      end
      if (c_rdy) begin
        cv_r <= fv_r;
      end
      if (o_rdy) begin
        ov_r <= cv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy && up_valid) begin
      f_r <= f_nxt;
    end
    if (c_rdy && fv_r) begin
      c_r <= c_nxt;
    end
    if (o_rdy && cv_r) begin
      if (c_r.err) begin
        energy_r <= '0;
        inf_r    <= 1'b0;
        ins_r    <= 1'b0;
        st_r     <= 1'b1;
      end else if (c_r.ovl) begin
        energy_r <= '0;
        inf_r    <= 1'b1;
        ins_r    <= 1'b0;
        st_r     <= 1'b0;
      end else begin
        energy_r <= energy_nxt;
        inf_r    <= 1'b0;
        ins_r    <= 1'b1;
        st_r     <= 1'b0;
      end
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.energy    = energy_r;
  assign out_if.infinite  = inf_r;
  assign out_if.is_inside = ins_r;
  assign out_if.status    = st_r;

endmodule

// File: sv/square_well_wall_energy.sv
// channel   dir   handshake     payload
// in_if     in    valid/ready   z_position, ensemble_state
// out_if    out   valid/ready   energy, infinite, is_inside, status
// cfg       in    cfg_we        cfg_index, cfg_data
//
// One word per cycle sustained while out_if is not stalled; the path is a multiply stage, the
// 32-step restoring divide pipeline (periodic wrap and state scaling),
// then wrap fixup, wall compares and the output register.
// rst_n is synchronous: clears all valid bits and loads register defaults.
// A stage holds while its successor is full and stalled; bubbles close up.
module square_well_wall_energy import swwe_pkg::*; #(
  parameter int MAX_STATES = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  swwe_in_if.sink            in_if,
  swwe_out_if.source         out_if,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  localparam logic [PosW-1:0] UpperRst = PosW'(64'd20 << FRAC_BITS);
  localparam logic [LenW-1:0] BoxRst   = LenW'(64'd20 << FRAC_BITS);
  localparam logic [LenW-1:0] DiamRst  = LenW'(64'd1 << FRAC_BITS);
  localparam logic [LenW-1:0] RangeRst = LenW'(64'd3 << (FRAC_BITS - 1));
  localparam logic [16:0]     MaxSt    = 17'(MAX_STATES);

  logic signed [PosW-1:0] lower_r;
  logic signed [PosW-1:0] upper_r;
  logic [LenW-1:0]        diam_r;
  logic [LenW-1:0]        range_r;
  logic [LenW-1:0]        depth_r;
  logic [NumW-1:0]        num_r;
  logic [LenW-1:0]        box_r;
  cfg_t                   cfg;

  logic      f_valid;
  logic      f_ready;
  div_word_t f_word;
  logic      d_valid;
  logic      d_ready;
  div_word_t d_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= $signed(UpperRst);
      diam_r  <= DiamRst;
      range_r <= RangeRst;
      depth_r <= DiamRst;
      num_r   <= 9'd1;
      box_r   <= BoxRst;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LOWER: lower_r <= $signed(cfg_data);
        REG_UPPER: upper_r <= $signed(cfg_data);
        REG_DIAM:  diam_r  <= cfg_data[LenW-1:0];
        REG_RANGE: range_r <= cfg_data[LenW-1:0];
        REG_DEPTH: depth_r <= cfg_data[LenW-1:0];
        REG_NUM:   num_r   <= cfg_data[NumW-1:0];
        REG_BOX:   box_r   <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.lower    = lower_r;
    cfg.upper    = upper_r;
    cfg.diam     = diam_r;
    cfg.well_rng = range_r;
    cfg.depth    = depth_r;
    cfg.box      = box_r;
    cfg.m_eff    = ({8'd0, num_r} > MaxSt) ? MaxSt[NumW-1:0] : num_r;
  end

  swwe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_if    (in_if),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_word  (f_word)
  );

  swwe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_word  (f_word),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_word  (d_word)
  );

  swwe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (d_valid),
    .up_ready (d_ready),
    .up_word  (d_word),
    .out_if   (out_if)
  );

endmodule

// File: sv/swwe_check.sv
module swwe_check import swwe_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [EnW-1:0] energy,
  input logic                  infinite,
  input logic                  is_inside,
  input logic                  status
);

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> energy == '0 && !infinite && !is_inside)
    else $error("error word carries a result");

  a_inf_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && infinite |-> !is_inside && energy == '0 && !status)
    else $error("overlap word not clean");

  a_inside_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_inside |-> energy[EnW-1] || energy == '0)
    else $error("positive energy inside");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(energy) && $stable(status))
    else $error("stalled word changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind square_well_wall_energy swwe_check u_swwe_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .energy    (out_if.energy),
  .infinite  (out_if.infinite),
  .is_inside (out_if.is_inside),
  .status    (out_if.status)
);

// File: test/square_well_wall_energy_test.sv
`timescale 1ns / 100ps

module square_well_wall_energy_test;
  import swwe_pkg::*;

  localparam int MaxStates  = 256;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 50;

  typedef struct packed {
    logic signed [EnW-1:0] energy;
    logic                  infinite;
    logic                  is_inside;
    logic                  status;
  } wall_result_t;

  typedef struct {
    logic signed [PosW-1:0] lower;
    logic signed [PosW-1:0] upper;
    logic [LenW-1:0]        diam;
    logic [LenW-1:0]        rng;
    logic [LenW-1:0]        depth;
    logic [NumW-1:0]        states;
    logic [LenW-1:0]        box;
  } wall_cfg_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  swwe_in_if  in_if ();
  swwe_out_if out_if ();

  wall_cfg_t    wc;
  wall_result_t energy_q[$];
  wall_result_t head_word;
  int           fail_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_left;

  square_well_wall_energy #(
    .MAX_STATES(MaxStates),
    .FRAC_BITS (16)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wall_result_t predict_wall_energy(logic signed [PosW-1:0] z_in,
                                                       logic [StW-1:0] st);
    wall_result_t r;
    longint z, m, d, eps, e, len;
    r = '0;
    m = longint'(wc.states);
    if (m > MaxStates) m = longint'(MaxStates);
    if (longint'(st) >= m) begin
      r.status = 1'b1;
      return r;
    end
    z = longint'(z_in);
    if (wc.box != 0) begin
      len = longint'(wc.box);
      z = z % len;
      if (z < 0) z += len;
    end
    d = longint'(wc.diam);
    eps = longint'(wc.depth);
    if (st > 0) begin
      d = (longint'(wc.diam) * longint'(st)) / m;
      eps = (longint'(wc.depth) * longint'(st)) / m;
    end
    if (2 * z >= 2 * longint'(wc.upper) - d || 2 * z <= 2 * longint'(wc.lower) + d) begin
      r.infinite = 1'b1;
      return r;
    end
    e = 0;
    if (z > longint'(wc.upper) - longint'(wc.rng)) e -= eps;
    if (z < longint'(wc.lower) + longint'(wc.rng)) e -= eps;
    r.energy = e[EnW-1:0];
    r.is_inside = 1'b1;
    return r;
  endfunction

  // mostly near a wall surface, sometimes shifted by whole box lengths
  function automatic logic signed [PosW-1:0] pick_z();
    longint z, span;
    span = longint'(wc.diam) + longint'(wc.rng) + 2;
    if (span > 64'd1073741824) span = 64'd1073741824;
    case ($urandom_range(9))
      0: return $urandom;
      1, 2, 3: z = longint'(wc.upper) + longint'($urandom_range(2 * span)) - span;
      4, 5, 6: z = longint'(wc.lower) + longint'($urandom_range(2 * span)) - span;
      default: z = (wc.box == 0) ? longint'($signed($urandom)) :
                                   longint'($urandom_range(wc.box));
    endcase
    if ($urandom_range(3) == 0) z += (longint'($urandom_range(4)) - 2) * longint'(wc.box);
    return z[PosW-1:0];
  endfunction

  function automatic logic [StW-1:0] pick_state();
    int m;
    m = (wc.states > MaxStates) ? MaxStates : int'(wc.states);
    if (m == 0 || $urandom_range(9) == 0) return StW'($urandom_range(255));
    return StW'($urandom_range(m - 1));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (energy_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        head_word = energy_q.pop_front();
        if (out_if.energy !== head_word.energy) begin
          $error("energy: expected %0d, got %0d", head_word.energy, out_if.energy);
          fail_count++;
        end
        if (out_if.infinite !== head_word.infinite) begin
          $error("infinite: expected %0d, got %0d", head_word.infinite, out_if.infinite);
          fail_count++;
        end
        if (out_if.is_inside !== head_word.is_inside) begin
          $error("is_inside: expected %0d, got %0d", head_word.is_inside, out_if.is_inside);
          fail_count++;
        end
        if (out_if.status !== head_word.status) begin
          $error("status: expected %0d, got %0d", head_word.status, out_if.status);
          fail_count++;
        end
      end
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input logic signed [PosW-1:0] z, input logic [StW-1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.z_position <= z;
    in_if.ensemble_state <= st;
    do @(posedge clk); while (!in_if.ready);
    energy_q.push_back(predict_wall_energy(z, st));
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (energy_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_walls(input logic signed [PosW-1:0] lo, hi,
                               input logic [LenW-1:0] dm, rg, dp,
                               input logic [NumW-1:0] ns, input logic [LenW-1:0] bx);
    stop_sending();
    wait_drained();
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, hi);
    write_reg(REG_DIAM, CfgW'(dm));
    write_reg(REG_RANGE, CfgW'(rg));
    write_reg(REG_DEPTH, CfgW'(dp));
    write_reg(REG_NUM, CfgW'(ns));
    write_reg(REG_BOX, CfgW'(bx));
    cfg_we <= 1'b0;
    wc.lower = lo;
    wc.upper = hi;
    wc.diam = dm;
    wc.rng = rg;
    wc.depth = dp;
    wc.states = ns;
    wc.box = bx;
  endtask

  task automatic test_reset_defaults();
    send_word(32'sd0, 8'd0);
    send_word(32'sd32768, 8'd0);
    send_word(32'sd32769, 8'd0);
    send_word(32'sd98304, 8'd0);
    send_word(32'sd1277952, 8'd0);
    send_word(32'sd1212417, 8'd0);
    send_word(-32'sd65536, 8'd0);
    send_word(32'sh7fffffff, 8'd0);
    send_word(32'sh80000000, 8'd0);
    send_word(32'sd655360, 8'd1);
    send_word(32'sd655360, 8'd255);
  endtask

  task automatic test_state_scaling();
    int s;
    program_walls(32'sd0, 32'sd655360, 31'd131072, 31'd131072, 31'd196608, 9'd4, 31'd0);
    for (s = 0; s <= 4; s++) send_word(32'sd65536, s[StW-1:0]);
    send_word(32'sd65536, 8'd255);
    send_word(-32'sd327680, 8'd2);
  endtask

  task automatic test_register_extremes();
    program_walls(32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                  9'd256, 31'h7fffffff);
    send_word(32'sh7fffffff, 8'd255);
    send_word(32'sh80000000, 8'd0);
    send_word(32'sd0, 8'd128);
    program_walls(32'sd0, 32'sd0, 31'd0, 31'd0, 31'd0, 9'd511, 31'd1);
    send_word(32'sd12345, 8'd200);
    send_word(-32'sd7, 8'd0);
    program_walls(-32'sd100, 32'sd100, 31'd0, 31'd0, 31'h7fffffff, 9'd0, 31'h7fffffff);
    send_word(32'sd0, 8'd0);
    send_word(32'sd50, 8'd255);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    logic signed [PosW-1:0] lo, hi;
    logic [LenW-1:0] bx, dm, rg, dp;
    logic [NumW-1:0] ns;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      if ($urandom_range(5) == 0) begin
        lo = $urandom;
        hi = $urandom;
        dm = LenW'($urandom);
        rg = LenW'($urandom);
        dp = LenW'($urandom);
        ns = NumW'($urandom);
        bx = LenW'($urandom);
      end else begin
        bx = LenW'($urandom_range(64 << 16, 2 << 16));
        lo = $urandom_range(bx / 4);
        hi = $urandom_range(bx, bx / 2);
        dm = LenW'($urandom_range(4 << 16));
        rg = LenW'($urandom_range(6 << 16));
        dp = LenW'($urandom_range(8 << 16));
        ns = $urandom_range(1) ? NumW'($urandom_range(8, 1)) : NumW'($urandom_range(256, 1));
      end
      program_walls(lo, hi, dm, rg, dp, ns, bx);
      repeat (80) send_word(pick_z(), pick_state());
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and block input
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stop_sending();
    hold_left <= 300;
    repeat (80) send_word(pick_z(), pick_state());
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (20) send_word(pick_z(), pick_state());
    stop_sending();
    wait_drained();
    repeat (20) send_word(pick_z(), pick_state());
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_LOWER;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.z_position = '0;
    in_if.ensemble_state = '0;
    out_if.ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    hold_left = 0;
    send_idle_pct = 10;
    recv_idle_pct = 50;
    wc.lower = 32'sd0;
    wc.upper = 32'sd1310720;
    wc.diam = 31'd65536;
    wc.rng = 31'd98304;
    wc.depth = 31'd65536;
    wc.states = 9'd1;
    wc.box = 31'd1310720;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_state_scaling();
    test_register_extremes();
    test_random_phase(10, 50);
    test_random_phase(50, 10);
    test_random_phase(0, 0);
    test_output_stall();
    test_drain_pause();

    stop_sending();
    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/swwe_pkg.sv
sv/swwe_ifs.sv
sv/swwe_front.sv
sv/swwe_div.sv
sv/swwe_back.sv
sv/square_well_wall_energy.sv
sv/swwe_check.sv
test/square_well_wall_energy_test.sv
